### hw/rtl/vubar_pkg.sv
// ----------------------------------------------------------------------------
// vubar_pkg: shared types and constants for the VU meter bar scanner
// Holds the threshold tables, the operation codes, the register indexes and
// the helper functions for the filter output and the bar level search.
// ----------------------------------------------------------------------------
package vubar_pkg;

   localparam int TAB_LEN    = 24;
   localparam int GROUP_LEDS = 6;
   localparam int GROUPS     = 4;
   localparam int SUM_W      = 15;
   localparam int LEVEL_W    = 5;
   localparam int GROUP_W    = 2;

   // Operation codes of one request beat.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SCAN   = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TABLE_SELECT = 2'd0;
   localparam logic [1:0] CSR_FILTER_SHIFT = 2'd1;
   localparam logic [1:0] CSR_DECAY_STEP   = 2'd2;

   localparam logic [4:0] DECAY_RESET = 5'd1;

   localparam logic [7:0] LIN_TABLE [TAB_LEN] = '{
        8'd5,   8'd16,  8'd26,  8'd37,  8'd48,  8'd58,  8'd69,  8'd80,
        8'd90,  8'd101, 8'd112, 8'd122, 8'd133, 8'd144, 8'd154, 8'd165,
        8'd176, 8'd186, 8'd197, 8'd208, 8'd218, 8'd229, 8'd240, 8'd250
   };

   localparam logic [7:0] LOG_TABLE [TAB_LEN] = '{
        8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd15,  8'd19,  8'd25,  8'd31,  8'd39,
        8'd49,  8'd62,  8'd79,  8'd99,  8'd125, 8'd157, 8'd198, 8'd250
   };

   typedef struct packed {
      logic       table_select;
      logic [2:0] filter_shift;
      logic [4:0] decay_step;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]   filter_sum;
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] peak;
   } meter_state_type;

   // Filter output: the sum shifted down, saturated to eight bits.
   function automatic logic [7:0] filter_out(logic [SUM_W-1:0] sum, logic [2:0] shift);
      logic [SUM_W-1:0] v;
      v = sum >> shift;
      if (v > SUM_W'(255)) begin
         filter_out = 8'hFF;
      end else begin
         filter_out = v[7:0];
      end
   endfunction

   // Bar level: index of the first threshold above the value, else the top.
   function automatic logic [LEVEL_W-1:0] find_level(logic [7:0] v, logic sel);
      logic [TAB_LEN-1:0] below;
      logic [LEVEL_W-1:0] lvl;
      for (int i = 0; i < TAB_LEN; i++) begin
         below[i] = sel ? (v < LOG_TABLE[i]) : (v < LIN_TABLE[i]);
      end
      lvl = LEVEL_W'(TAB_LEN - 1);
      for (int i = TAB_LEN - 1; i >= 0; i--) begin
         if (below[i]) begin
            lvl = LEVEL_W'(i);
         end
      end
      find_level = lvl;
   endfunction

endpackage

### hw/rtl/vubar_meter.sv
// ----------------------------------------------------------------------------
// vubar_meter: filter, bar level and peak-hold update for one sample
// Computes the next meter state from the current one and a new sample, and
// the filter output both before and after the update.
// ----------------------------------------------------------------------------
module vubar_meter
   import vubar_pkg::*;
(
   input  cfg_type         cfg,
   input  meter_state_type state_cur,
   input  logic [7:0]      sample,
   output meter_state_type state_next,
   output logic [7:0]      filtered_cur,
   output logic [7:0]      filtered_next
);

   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_next;
   logic [LEVEL_W-1:0]   level_next;
   logic [LEVEL_W-1:0]   peak_next;

   // First-order low-pass: sum += x - (sum >> shift), kept to the sum width.
   always_comb begin
      sum_wide = {1'b0, state_cur.filter_sum}
               - ({1'b0, state_cur.filter_sum} >> cfg.filter_shift)
               + (SUM_W+1)'(sample);
      sum_next = sum_wide[SUM_W-1:0];
   end

   assign filtered_cur  = filter_out(state_cur.filter_sum, cfg.filter_shift);
   assign filtered_next = filter_out(sum_next, cfg.filter_shift);
   assign level_next    = find_level(filtered_next, cfg.table_select);

   // The peak jumps up to the level, otherwise decays and stops at zero.
   always_comb begin
      if (level_next >= state_cur.peak) begin
         peak_next = level_next;
      end else if (state_cur.peak >= cfg.decay_step) begin
         peak_next = state_cur.peak - cfg.decay_step;
      end else begin
         peak_next = '0;
      end
   end

   assign state_next.filter_sum = sum_next;
   assign state_next.level      = level_next;
   assign state_next.peak       = peak_next;

endmodule

### hw/rtl/vubar_scan.sv
// ----------------------------------------------------------------------------
// vubar_scan: LED pattern for one multiplexed display group
// Lights each of the group's LEDs at or below the bar level, and the one
// that sits on the peak-hold position.
// ----------------------------------------------------------------------------
module vubar_scan
   import vubar_pkg::*;
(
   input  logic [GROUP_W-1:0]    group,
   input  logic [LEVEL_W-1:0]    level,
   input  logic [LEVEL_W-1:0]    peak,
   output logic [GROUP_LEDS-1:0] pattern
);

   // Each LED position is compared on its own.
   always_comb begin
      logic [LEVEL_W-1:0] pos;
      for (int k = 0; k < GROUP_LEDS; k++) begin
         pos = LEVEL_W'(group) * LEVEL_W'(GROUP_LEDS) + LEVEL_W'(k) + LEVEL_W'(1);
         pattern[k] = (level >= pos) || (peak == pos);
      end
   end

endmodule

### hw/rtl/vu_meter_bar_peak_scanner_top.sv
// ----------------------------------------------------------------------------
// vu_meter_bar_peak_scanner_top: LED bar VU meter with peak hold and scan
// Two register stages: a request register and a result register.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock cycle while req_stall is low,
// and returns one response beat for each through the request register and
// then the result register. A sample beat updates the low-pass filter, the
// bar level and the peak hold; a scan beat returns the LED pattern of the
// current display group and moves to the next group. The rate of one beat
// per cycle is set by the filter and peak state loop, closed combinationally
// between the request register and the result register. A stalled response
// holds the result register, and the request register still takes one more
// beat before the request side is stalled. The user must write configuration
// via the csr_ port while no beat is in flight; the block does not enforce it.
module vu_meter_bar_peak_scanner_top
   import vubar_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [4:0]            csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [7:0]            req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_filtered,
   output logic [LEVEL_W-1:0]    rsp_bar_level,
   output logic [LEVEL_W-1:0]    rsp_peak_level,
   output logic [GROUP_W-1:0]    rsp_group_enable,
   output logic [GROUP_LEDS-1:0] rsp_led_pattern
);

   cfg_type               cfg_ff;
   meter_state_type       meter_ff;
   meter_state_type       meter_in;
   meter_state_type       meter_next;
   logic [GROUP_W-1:0]    group_ff;
   logic [GROUP_W-1:0]    group_in;

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [7:0]            in_sample_ff;

   logic                  out_valid_ff;
   logic [7:0]            out_filtered_ff;
   logic [7:0]            out_filtered_in;
   logic [LEVEL_W-1:0]    out_level_ff;
   logic [LEVEL_W-1:0]    out_peak_ff;
   logic [GROUP_W-1:0]    out_group_ff;
   logic [GROUP_W-1:0]    out_group_in;
   logic [GROUP_LEDS-1:0] out_pattern_ff;
   logic [GROUP_LEDS-1:0] out_pattern_in;

   logic [7:0]            filtered_cur;
   logic [7:0]            filtered_next;
   logic [GROUP_LEDS-1:0] scan_pattern;
   logic                  out_load;
   logic                  in_load;

   // Pipeline handshake between the two register stages.
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_select <= 1'b0;
         cfg_ff.filter_shift <= 3'd0;
         cfg_ff.decay_step   <= DECAY_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TABLE_SELECT: cfg_ff.table_select <= csr_wdata[0];
            CSR_FILTER_SHIFT: cfg_ff.filter_shift <= csr_wdata[2:0];
            CSR_DECAY_STEP:   cfg_ff.decay_step   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_op_ff     <= req_operation;
         in_sample_ff <= req_sample;
      end
   end

   vubar_meter u_meter (
      .cfg           (cfg_ff),
      .state_cur     (meter_ff),
      .sample        (in_sample_ff),
      .state_next    (meter_next),
      .filtered_cur  (filtered_cur),
      .filtered_next (filtered_next)
   );

   vubar_scan u_scan (
      .group   (group_ff),
      .level   (meter_ff.level),
      .peak    (meter_ff.peak),
      .pattern (scan_pattern)
   );

   // Select the next state and the result of the beat in the request register.
   always_comb begin
      if (in_op_ff == OP_SAMPLE) begin
         meter_in        = meter_next;
         group_in        = group_ff;
         out_filtered_in = filtered_next;
         out_group_in    = '0;
         out_pattern_in  = '0;
      end else begin
         meter_in        = meter_ff;
         group_in        = group_ff + GROUP_W'(1);
         out_filtered_in = filtered_cur;
         out_group_in    = group_ff;
         out_pattern_in  = scan_pattern;
      end
   end

   // Meter state and scan group, updated as each beat completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         meter_ff <= '0;
         group_ff <= '0;
      end else if (out_load) begin
         meter_ff <= meter_in;
         group_ff <= group_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_filtered_ff <= out_filtered_in;
         out_level_ff    <= meter_in.level;
         out_peak_ff     <= meter_in.peak;
         out_group_ff    <= out_group_in;
         out_pattern_ff  <= out_pattern_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_filtered     = out_filtered_ff;
   assign rsp_bar_level    = out_level_ff;
   assign rsp_peak_level   = out_peak_ff;
   assign rsp_group_enable = out_group_ff;
   assign rsp_led_pattern  = out_pattern_ff;

endmodule

### hw/rtl/vubar_checker.sv
// ----------------------------------------------------------------------------
// vubar_checker: port-level assertions for the VU meter bar scanner
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module vubar_checker
   import vubar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  csr_write_en,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_operation,
   input logic [7:0]            req_sample,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [7:0]            rsp_filtered,
   input logic [LEVEL_W-1:0]    rsp_bar_level,
   input logic [LEVEL_W-1:0]    rsp_peak_level,
   input logic [GROUP_W-1:0]    rsp_group_enable,
   input logic [GROUP_LEDS-1:0] rsp_led_pattern
);

   // A stalled response beat stays and holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered)
         && $stable(rsp_bar_level) && $stable(rsp_peak_level)
         && $stable(rsp_group_enable) && $stable(rsp_led_pattern))
      else $error("response beat changed while stalled");

   // A stalled request beat stays and holds its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_operation)
         && $stable(req_sample))
      else $error("request beat changed while stalled");

   // Both levels stay within the table range.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bar_level < LEVEL_W'(TAB_LEN))
         && (rsp_peak_level < LEVEL_W'(TAB_LEN)))
      else $error("level out of range");

   // Register writes only land while no beat is on either channel.
   a_csr_quiet: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |-> !rsp_valid && !req_valid)
      else $error("register written while a beat is in flight");

   // Reset empties the pipeline and opens the request side.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not cleared by reset");

endmodule

bind vu_meter_bar_peak_scanner_top vubar_checker u_checker (.*);

### bench/tb_vu_meter_bar_peak_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_vu_meter_bar_peak_scanner_top: self-checking bench for the VU meter bar
// A queue-fed driver sends sample and scan beats, and writes the registers
// between phases once the block is quiet. A monitor checks every response
// beat against an in-bench model of the filter, bar, peak hold and scan.
// ----------------------------------------------------------------------------
module tb_vu_meter_bar_peak_scanner_top;
   import vubar_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int MAX_REPORTS   = 40;

   // Threshold tables of the bar search, lowest step first.
   localparam logic [0:23][7:0] LINEAR_STEPS = '{
      8'd5,   8'd16,  8'd26,  8'd37,  8'd48,  8'd58,  8'd69,  8'd80,
      8'd90,  8'd101, 8'd112, 8'd122, 8'd133, 8'd144, 8'd154, 8'd165,
      8'd176, 8'd186, 8'd197, 8'd208, 8'd218, 8'd229, 8'd240, 8'd250
   };
   localparam logic [0:23][7:0] LOG_STEPS = '{
      8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,
      8'd10,  8'd11,  8'd12,  8'd15,  8'd19,  8'd25,  8'd31,  8'd39,
      8'd49,  8'd62,  8'd79,  8'd99,  8'd125, 8'd157, 8'd198, 8'd250
   };

   typedef struct packed {
      logic [7:0]            filtered;
      logic [LEVEL_W-1:0]    bar_level;
      logic [LEVEL_W-1:0]    peak_level;
      logic [GROUP_W-1:0]    group_enable;
      logic [GROUP_LEDS-1:0] led_pattern;
   } meter_beat_type;

   typedef enum logic [1:0] {PLAN_BEAT, PLAN_CSR, PLAN_DRAIN, PLAN_MODE} plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic          op;
      logic [7:0]    value;
      logic [1:0]    index;
      int            send_pct;
      int            recv_pct;
   } plan_entry_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [1:0]            csr_index      = '0;
   logic [4:0]            csr_wdata      = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_operation  = OP_SAMPLE;
   logic [7:0]            req_sample     = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [7:0]            rsp_filtered;
   logic [LEVEL_W-1:0]    rsp_bar_level;
   logic [LEVEL_W-1:0]    rsp_peak_level;
   logic [GROUP_W-1:0]    rsp_group_enable;
   logic [GROUP_LEDS-1:0] rsp_led_pattern;

   plan_entry_type stim_plan[$];
   meter_beat_type expected_beats[$];
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             quiet_cycles  = 0;
   int             mismatch_count = 0;

   // Model state, starting from the reset values of the block.
   cfg_type            model_cfg   = '{table_select: 1'b0, filter_shift: 3'd0,
                                       decay_step: 5'd1};
   logic [SUM_W-1:0]   model_sum   = '0;
   logic [LEVEL_W-1:0] model_level = '0;
   logic [LEVEL_W-1:0] model_peak  = '0;
   logic [GROUP_W-1:0] model_group = '0;

   vu_meter_bar_peak_scanner_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .rsp_bar_level    (rsp_bar_level),
      .rsp_peak_level   (rsp_peak_level),
      .rsp_group_enable (rsp_group_enable),
      .rsp_led_pattern  (rsp_led_pattern)
   );

   // Free-running clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the meter model by one accepted beat and return its response.
   function automatic meter_beat_type meter_advance(logic op, logic [7:0] smp);
      meter_beat_type  r;
      logic [15:0]     acc;
      logic [SUM_W-1:0] shifted;
      logic [7:0]      level_in;
      logic            found;
      int              pos;
      r = '0;
      if (op == OP_SAMPLE) begin
         acc = {1'b0, model_sum} - ({1'b0, model_sum} >> model_cfg.filter_shift)
               + {8'd0, smp};
         model_sum = acc[SUM_W-1:0];
      end
      // The filter output saturates when a smaller shift meets a large sum.
      shifted = model_sum >> model_cfg.filter_shift;
      level_in = (shifted > 15'd255) ? 8'hFF : shifted[7:0];
      if (op == OP_SAMPLE) begin
         found = 1'b0;
         model_level = 5'd23;
         for (int i = 0; i < 24; i++) begin
            if (!found && (model_cfg.table_select ? (level_in < LOG_STEPS[i])
                                                  : (level_in < LINEAR_STEPS[i]))) begin
               model_level = i[4:0];
               found = 1'b1;
            end
         end
         // The peak jumps up to the level and otherwise decays toward zero.
         if (model_level >= model_peak) begin
            model_peak = model_level;
         end else if (model_peak >= model_cfg.decay_step) begin
            model_peak = model_peak - model_cfg.decay_step;
         end else begin
            model_peak = '0;
         end
      end else begin
         r.group_enable = model_group;
         for (int k = 0; k < GROUP_LEDS; k++) begin
            pos = int'(model_group) * GROUP_LEDS + k + 1;
            if (int'(model_level) >= pos || int'(model_peak) == pos) begin
               r.led_pattern[k] = 1'b1;
            end
         end
         model_group = model_group + 2'd1;
      end
      r.filtered   = level_in;
      r.bar_level  = model_level;
      r.peak_level = model_peak;
      return r;
   endfunction

   task automatic plan_beat(logic op, logic [7:0] smp);
      plan_entry_type e;
      e = '{kind: PLAN_BEAT, op: op, value: smp, index: 2'd0, send_pct: 0, recv_pct: 0};
      stim_plan.push_back(e);
   endtask

   task automatic plan_csr(logic [1:0] idx, logic [4:0] val);
      plan_entry_type e;
      e = '{kind: PLAN_CSR, op: OP_SAMPLE, value: {3'd0, val}, index: idx,
            send_pct: 0, recv_pct: 0};
      stim_plan.push_back(e);
   endtask

   task automatic plan_mode(int send_pct, int recv_pct);
      plan_entry_type e;
      e = '{kind: PLAN_MODE, op: OP_SAMPLE, value: 8'd0, index: 2'd0,
            send_pct: send_pct, recv_pct: recv_pct};
      stim_plan.push_back(e);
   endtask

   // Random beats: a quarter scans, and the samples lean on the extremes so
   // the bar swings fully and the peak hold has room to decay.
   task automatic plan_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            plan_beat(OP_SCAN, 8'($urandom_range(0, 255)));
         end else if (pick < 35) begin
            plan_beat(OP_SAMPLE, 8'd255);
         end else if (pick < 45) begin
            plan_beat(OP_SAMPLE, 8'd0);
         end else begin
            plan_beat(OP_SAMPLE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
         mismatch_count++;
      end
   endtask

   // Driver: presents request beats from the plan, and holds off register
   // writes and drain points until no beat is in flight.
   always @(posedge clock) begin : drive_proc
      logic           nxt_valid;
      logic           nxt_op;
      logic           nxt_wen;
      logic [7:0]     nxt_sample;
      logic [1:0]     nxt_index;
      logic [4:0]     nxt_wdata;
      plan_entry_type head;
      nxt_valid  = req_valid;
      nxt_op     = req_operation;
      nxt_sample = req_sample;
      nxt_wen    = 1'b0;
      nxt_index  = csr_index;
      nxt_wdata  = csr_wdata;
      if (reset) begin
         nxt_valid = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_beats.push_back(meter_advance(req_operation, req_sample));
         end
         if (expected_beats.size() == 0 && !req_valid) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         // A stalled beat stays on the bus unchanged.
         if (!(req_valid && req_stall)) begin
            nxt_valid = 1'b0;
            while (stim_plan.size() > 0 && stim_plan[0].kind == PLAN_MODE) begin
               send_idle_pct = stim_plan[0].send_pct;
               recv_idle_pct = stim_plan[0].recv_pct;
               void'(stim_plan.pop_front());
            end
            if (stim_plan.size() > 0) begin
               head = stim_plan[0];
               if (head.kind == PLAN_BEAT) begin
                  if ($urandom_range(0, 99) >= send_idle_pct) begin
                     nxt_valid  = 1'b1;
                     nxt_op     = head.op;
                     nxt_sample = head.value;
                     void'(stim_plan.pop_front());
                  end
               end else if (quiet_cycles >= SETTLE_CYCLES) begin
                  if (head.kind == PLAN_CSR) begin
                     nxt_wen   = 1'b1;
                     nxt_index = head.index;
                     nxt_wdata = head.value[4:0];
                     case (head.index)
                        CSR_TABLE_SELECT: model_cfg.table_select = head.value[0];
                        CSR_FILTER_SHIFT: model_cfg.filter_shift = head.value[2:0];
                        CSR_DECAY_STEP:   model_cfg.decay_step   = head.value[4:0];
                        default: ;
                     endcase
                  end
                  void'(stim_plan.pop_front());
               end
            end
         end
      end
      req_valid     <= nxt_valid;
      req_operation <= nxt_op;
      req_sample    <= nxt_sample;
      csr_write_en  <= nxt_wen;
      csr_index     <= nxt_index;
      csr_wdata     <= nxt_wdata;
   end

   // Monitor: checks each accepted response beat and drives a random stall.
   always @(posedge clock) begin : watch_proc
      meter_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               if (mismatch_count < MAX_REPORTS) begin
                  $display("%0t: response beat with none expected, actual filtered %0d",
                           $time, rsp_filtered);
               end
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("filtered", want.filtered, rsp_filtered);
               check_field("bar_level", 8'(want.bar_level), 8'(rsp_bar_level));
               check_field("peak_level", 8'(want.peak_level), 8'(rsp_peak_level));
               check_field("group_enable", 8'(want.group_enable), 8'(rsp_group_enable));
               check_field("led_pattern", 8'(want.led_pattern), 8'(rsp_led_pattern));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Stimulus plan, reset, and the end of the run.
   initial begin
      plan_mode(13, 68);
      // Full swing on the reset settings, with scans over all four groups.
      plan_beat(OP_SAMPLE, 8'd0);
      plan_beat(OP_SCAN, 8'd255);
      plan_beat(OP_SAMPLE, 8'd255);
      repeat (4) plan_beat(OP_SCAN, 8'd0);
      plan_beat(OP_SAMPLE, 8'd0);
      repeat (4) plan_beat(OP_SCAN, 8'd170);
      plan_beat(OP_SAMPLE, 8'd5);
      plan_beat(OP_SAMPLE, 8'd4);
      plan_beat(OP_SAMPLE, 8'd250);
      plan_beat(OP_SAMPLE, 8'd239);
      // A decay step larger than the peak drops it to zero.
      plan_csr(CSR_TABLE_SELECT, 5'd1);
      plan_csr(CSR_DECAY_STEP, 5'd23);
      plan_beat(OP_SAMPLE, 8'd1);
      plan_beat(OP_SAMPLE, 8'd100);
      plan_beat(OP_SAMPLE, 8'd170);
      plan_beat(OP_SAMPLE, 8'd100);
      plan_beat(OP_SCAN, 8'd85);
      // With no decay the peak holds at the top.
      plan_csr(CSR_DECAY_STEP, 5'd0);
      plan_beat(OP_SAMPLE, 8'd255);
      plan_beat(OP_SAMPLE, 8'd0);
      plan_beat(OP_SCAN, 8'd0);

      plan_csr(CSR_TABLE_SELECT, 5'd0);
      plan_csr(CSR_FILTER_SHIFT, 5'd2);
      plan_csr(CSR_DECAY_STEP, 5'd3);
      plan_random(250);
      plan_csr(CSR_TABLE_SELECT, 5'd1);
      plan_csr(CSR_FILTER_SHIFT, 5'd7);
      plan_csr(CSR_DECAY_STEP, 5'd0);
      plan_random(250);
      // Dropping the shift on a large sum saturates the filter output.
      plan_csr(CSR_FILTER_SHIFT, 5'd0);
      plan_beat(OP_SCAN, 8'd0);
      plan_beat(OP_SAMPLE, 8'd9);

      plan_mode(68, 13);
      plan_csr(CSR_TABLE_SELECT, 5'd0);
      plan_csr(CSR_FILTER_SHIFT, 5'd7);
      plan_csr(CSR_DECAY_STEP, 5'd23);
      plan_random(125);
      // Hold the sender until every response beat has come back.
      stim_plan.push_back('{kind: PLAN_DRAIN, op: OP_SAMPLE, value: 8'd0, index: 2'd0,
                            send_pct: 0, recv_pct: 0});
      plan_random(125);
      plan_csr(CSR_FILTER_SHIFT, 5'd3);
      plan_csr(CSR_DECAY_STEP, 5'd12);
      plan_random(250);

      plan_mode(0, 0);
      plan_csr(CSR_TABLE_SELECT, 5'($urandom_range(0, 1)));
      plan_csr(CSR_FILTER_SHIFT, 5'($urandom_range(0, 7)));
      plan_csr(CSR_DECAY_STEP, 5'($urandom_range(0, 23)));
      plan_random(250);
      plan_csr(CSR_TABLE_SELECT, 5'd1);
      plan_csr(CSR_FILTER_SHIFT, 5'd1);
      plan_csr(CSR_DECAY_STEP, 5'd1);
      plan_random(200);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stim_plan.size() != 0 || expected_beats.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("tb_vu_meter_bar_peak_scanner_top: clean");
      end else begin
         $display("tb_vu_meter_bar_peak_scanner_top: errors");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #400000;
      $display("tb_vu_meter_bar_peak_scanner_top: errors");
      $finish;
   end

endmodule

### vu_meter_bar_peak_scanner_top.f
hw/rtl/vubar_pkg.sv
hw/rtl/vubar_meter.sv
hw/rtl/vubar_scan.sv
hw/rtl/vu_meter_bar_peak_scanner_top.sv
hw/rtl/vubar_checker.sv
bench/tb_vu_meter_bar_peak_scanner_top.sv
